// ===== rtl/pgh_pkg.sv =====
// Package for the PS2 gamepad host interface: sizes, link phase codes,
// command byte codes and the link event carried from the front to the back.
// No dependencies.
package pgh_pkg;

	localparam int FRAME_BYTES = 9;
	localparam int SHORT_POLLS = 3;

	localparam int STEP_ENTER  = SHORT_POLLS;
	localparam int STEP_ANALOG = SHORT_POLLS + 1;
	localparam int STEP_VIBMAP = SHORT_POLLS + 2;
	localparam int STEP_EXIT   = SHORT_POLLS + 3;
	localparam int STEP_POLL   = SHORT_POLLS + 4;

	localparam int FRAME_MAX = (FRAME_BYTES > 9) ? FRAME_BYTES : 9;
	localparam int BIDX_W    = $clog2(FRAME_MAX + 1);
	localparam int STEP_W    = $clog2(STEP_POLL + 1);

	// configuration register indexes
	localparam logic [1:0] CFG_GAP    = 2'd0;
	localparam logic [1:0] CFG_ANALOG = 2'd1;
	localparam logic [1:0] CFG_LOCK   = 2'd2;

	localparam logic [3:0] GAP_RESET    = 4'd3;
	localparam logic       ANALOG_RESET = 1'b1;
	localparam logic [7:0] LOCK_RESET   = 8'h03;

	// command bytes
	localparam logic [7:0] CMD_START  = 8'h01;
	localparam logic [7:0] CMD_POLL   = 8'h42;
	localparam logic [7:0] CMD_CONFIG = 8'h43;
	localparam logic [7:0] CMD_MODE   = 8'h44;
	localparam logic [7:0] CMD_VIBMAP = 8'h4D;
	localparam logic [7:0] CMD_PAD    = 8'h5A;
	localparam logic [7:0] CMD_ONE    = 8'h01;
	localparam logic [7:0] CMD_ZERO   = 8'h00;

	localparam logic [7:0] MODE_ANALOG_RED = 8'h73;
	localparam logic [7:0] BYTE_FULL       = 8'hFF;
	localparam logic [7:0] STICK_MID_X     = 8'd128;
	localparam logic [7:0] STICK_MID_Y     = 8'd127;

	typedef enum logic [3:0] {
		PH_LEAD = 4'b0001,
		PH_BITS = 4'b0010,
		PH_GAP  = 4'b0100,
		PH_TAIL = 4'b1000
	} phase_t;

	// one accepted tick as seen by the back end
	typedef struct packed {
		logic              sel;
		logic              clk;
		logic              dout;
		logic              cap;
		logic [BIDX_W-1:0] cap_idx;
		logic [7:0]        cap_val;
		logic              done;
		logic              busy;
	} link_ev_t;

endpackage

// ===== rtl/ps2_gamepad_host_interface.sv =====
// Top level of the PS2 gamepad host interface: front sequencer, event
// queue and result back end. Depends on pgh_pkg, pgh_front, pgh_queue, pgh_back.
//
// Each accepted tick item is one base tick of the gamepad link and yields
// exactly one result item with the pin levels for that tick and the held
// pad state. One tick is taken every cycle: the front sequencer computes the
// link state combinationally, a two-entry queue decouples it from the result
// register, and each tick passes a queue slot and then the result register.
// Input stalls only while the queue is full because the result side stalls.
// After reset the block runs the init frames (short polls, enter config,
// mode set, vibration map, exit config) and then repeats poll frames;
// frame_done marks the tick on which new pad values were latched. Config
// writes take effect on the next tick; write them while no ticks flow.
module ps2_gamepad_host_interface import pgh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        tick_valid,
	output logic        tick_stall,
	input  logic        data_in,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        select_n,
	output logic        clock_pin,
	output logic        data_out,
	output logic        frame_done,
	output logic [15:0] buttons,
	output logic [7:0]  right_x,
	output logic [7:0]  right_y,
	output logic [7:0]  left_x,
	output logic [7:0]  left_y,
	output logic [7:0]  mode_id,
	output logic        is_analog,
	output logic        init_busy
);

	link_ev_t push_ev, head_ev;
	logic     push, not_full, not_empty, pop;

	assign tick_stall = !not_full;

	pgh_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.tick_valid (tick_valid),
		.data_in    (data_in),
		.push_ok    (not_full),
		.push       (push),
		.ev         (push_ev)
	);

	pgh_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_ev   (push_ev),
		.not_full  (not_full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head_ev)
	);

	pgh_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.ev_ready     (not_empty),
		.ev           (head_ev),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.select_n     (select_n),
		.clock_pin    (clock_pin),
		.data_out     (data_out),
		.frame_done   (frame_done),
		.buttons      (buttons),
		.right_x      (right_x),
		.right_y      (right_y),
		.left_x       (left_x),
		.left_y       (left_y),
		.mode_id      (mode_id),
		.is_analog    (is_analog),
		.init_busy    (init_busy)
	);

endmodule

// ===== rtl/pgh_front.sv =====
// Front end of the PS2 gamepad host: configuration registers, frame
// sequencer and bit timing. Emits one link event per accepted tick.
// Depends on pgh_pkg.
module pgh_front import pgh_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       tick_valid,
	input  logic       data_in,
	input  logic       push_ok,
	output logic       push,
	output link_ev_t   ev
);

	logic [3:0]        gap_cfg_q;
	logic              analog_q;
	logic [7:0]        lock_q;
	logic [STEP_W-1:0] step_q, step_n;
	logic [BIDX_W-1:0] bidx_q, bidx_n;
	logic [2:0]        bit_q, bit_n;
	logic              half_q, half_n;
	logic [3:0]        gap_q, gap_n;
	logic [7:0]        shift_q, shift_n;
	logic [3:0]        ff_q, ff_n;
	logic              reinit_q, reinit_n;
	phase_t            phase_q, phase_n;

	function automatic logic [BIDX_W-1:0] frame_len(input logic [STEP_W-1:0] s);
		if (s < STEP_W'(STEP_ENTER) || s == STEP_W'(STEP_VIBMAP))
			return BIDX_W'(5);
		if (s < STEP_W'(STEP_POLL))
			return BIDX_W'(9);
		return BIDX_W'(FRAME_BYTES);
	endfunction

	function automatic logic [7:0] command_byte(input logic [STEP_W-1:0] s,
		input logic [BIDX_W-1:0] i, input logic an, input logic [7:0] lk);
		if (i == BIDX_W'(0))
			return CMD_START;
		if (s < STEP_W'(STEP_ENTER))
			return (i == BIDX_W'(1)) ? CMD_POLL : CMD_ZERO;
		if (s == STEP_W'(STEP_ENTER))
			return (i == BIDX_W'(1)) ? CMD_CONFIG : ((i == BIDX_W'(3)) ? CMD_ONE : CMD_ZERO);
		if (s == STEP_W'(STEP_ANALOG)) begin
			if (i == BIDX_W'(1)) return CMD_MODE;
			if (i == BIDX_W'(3)) return {7'd0, an};
			if (i == BIDX_W'(4)) return lk;
			return CMD_ZERO;
		end
		if (s == STEP_W'(STEP_VIBMAP))
			return (i == BIDX_W'(1)) ? CMD_VIBMAP : ((i == BIDX_W'(4)) ? CMD_ONE : CMD_ZERO);
		if (s == STEP_W'(STEP_EXIT))
			return (i == BIDX_W'(1)) ? CMD_CONFIG :
				((i >= BIDX_W'(4) && i <= BIDX_W'(8)) ? CMD_PAD : CMD_ZERO);
		return (i == BIDX_W'(1)) ? CMD_POLL : CMD_ZERO;
	endfunction

	assign push = tick_valid && push_ok;

	always_comb begin
		logic [BIDX_W-1:0] len;
		logic [7:0]        cmd;
		logic [3:0]        need;
		logic              poll;
		len      = frame_len(step_q);
		cmd      = command_byte(step_q, bidx_q, analog_q, lock_q);
		need     = (gap_cfg_q == 4'd0) ? 4'd1 : gap_cfg_q;
		poll     = (step_q >= STEP_W'(STEP_POLL));
		step_n   = step_q;
		bidx_n   = bidx_q;
		bit_n    = bit_q;
		half_n   = half_q;
		gap_n    = gap_q;
		shift_n  = shift_q;
		ff_n     = ff_q;
		reinit_n = reinit_q;
		phase_n  = phase_q;
		ev       = '0;
		ev.clk   = 1'b1;
		unique case (phase_q)
			PH_BITS: begin
				ev.dout = cmd[bit_q];
				if (!half_q) begin
					ev.clk = 1'b0;
					half_n = 1'b1;
				end else begin
					half_n = 1'b0;
					shift_n = (bit_q == 3'd0) ? 8'h00 : shift_q;
					shift_n[bit_q] = data_in;
					if (bit_q != 3'd7) begin
						bit_n = bit_q + 3'd1;
					end else begin
						bit_n = 3'd0;
						if (poll && bidx_q >= BIDX_W'(1) && bidx_q <= BIDX_W'(8)) begin
							ev.cap     = 1'b1;
							ev.cap_idx = bidx_q;
							ev.cap_val = shift_n;
						end
						// track all-0xFF sticks for the re-init decision
						if (poll) begin
							for (int k = 0; k < 4; k++)
								if (bidx_q == BIDX_W'(k + 5))
									ff_n[k] = (shift_n == BYTE_FULL);
						end
						bidx_n = bidx_q + BIDX_W'(1);
						if (bidx_n >= len && poll) begin
							ev.done = 1'b1;
							if (&ff_n)
								reinit_n = 1'b1;
						end
						gap_n = 4'd0;
						if (gap_cfg_q == 4'd0)
							phase_n = (bidx_n >= len) ? PH_TAIL : PH_BITS;
						else
							phase_n = PH_GAP;
					end
				end
			end
			PH_TAIL: begin
				ev.sel = 1'b1;
				gap_n  = gap_q + 4'd1;
				if (gap_n >= need) begin
					if (!poll) begin
						step_n = step_q + STEP_W'(1);
					end else if (reinit_q) begin
						step_n   = '0;
						reinit_n = 1'b0;
					end else begin
						step_n = STEP_W'(STEP_POLL);
					end
					bidx_n  = '0;
					bit_n   = 3'd0;
					half_n  = 1'b0;
					gap_n   = 4'd0;
					phase_n = (gap_cfg_q == 4'd0) ? PH_BITS : PH_LEAD;
				end
			end
			PH_LEAD, PH_GAP: begin
				gap_n = gap_q + 4'd1;
				if (gap_n >= gap_cfg_q) begin
					gap_n   = 4'd0;
					phase_n = (phase_q == PH_LEAD || bidx_q < len) ? PH_BITS : PH_TAIL;
				end
			end
			default: begin
				phase_n = PH_LEAD;
			end
		endcase
		ev.busy = (step_n < STEP_W'(STEP_POLL));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_cfg_q <= GAP_RESET;
			analog_q  <= ANALOG_RESET;
			lock_q    <= LOCK_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_GAP:    gap_cfg_q <= cfg_data[3:0];
				CFG_ANALOG: analog_q  <= cfg_data[0];
				CFG_LOCK:   lock_q    <= cfg_data;
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= '0;
			bidx_q   <= '0;
			bit_q    <= 3'd0;
			half_q   <= 1'b0;
			gap_q    <= 4'd0;
			shift_q  <= 8'h00;
			ff_q     <= 4'd0;
			reinit_q <= 1'b0;
			phase_q  <= PH_LEAD;
		end else if (push) begin
			step_q   <= step_n;
			bidx_q   <= bidx_n;
			bit_q    <= bit_n;
			half_q   <= half_n;
			gap_q    <= gap_n;
			shift_q  <= shift_n;
			ff_q     <= ff_n;
			reinit_q <= reinit_n;
			phase_q  <= phase_n;
		end
	end

	a_bit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_BITS |-> (bit_q == 3'd0 && !half_q))
		else $error("bit counter moved outside the bit phase");

	a_reinit_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(reinit_q) |-> $past(push && ev.done))
		else $error("re-init armed without a finished poll frame");

endmodule

// ===== rtl/pgh_queue.sv =====
// Two-entry queue of link events between the front and the back end.
// Depends on pgh_pkg.
module pgh_queue import pgh_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  link_ev_t push_ev,
	output logic     not_full,
	input  logic     pop,
	output logic     not_empty,
	output link_ev_t head
);

	link_ev_t   slot_q [2];
	logic       wr_q, rd_q;
	logic [1:0] count_q;

	assign not_full  = (count_q != 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= push_ev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: ;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && !pop && count_q == 2'd2) && !(pop && count_q == 2'd0))
		else $error("queue overflow or underflow");

endmodule

// ===== rtl/pgh_back.sv =====
// Back end of the PS2 gamepad host: reply byte store, held results and
// the registered result item. Depends on pgh_pkg.
module pgh_back import pgh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        ev_ready,
	input  link_ev_t    ev,
	output logic        pop,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        select_n,
	output logic        clock_pin,
	output logic        data_out,
	output logic        frame_done,
	output logic [15:0] buttons,
	output logic [7:0]  right_x,
	output logic [7:0]  right_y,
	output logic [7:0]  left_x,
	output logic [7:0]  left_y,
	output logic [7:0]  mode_id,
	output logic        is_analog,
	output logic        init_busy
);

	logic [7:0]  reply_q [7];
	logic [7:0]  reply_n [7];
	logic [7:0]  mreply_q, mreply_n;
	logic [15:0] hbtn_q, hbtn_n;
	logic [7:0]  hstk_q [4];
	logic [7:0]  hstk_n [4];
	logic [7:0]  hmode_q, hmode_n;
	logic        valid_q;

	assign pop = ev_ready && (!valid_q || !result_stall);
	assign result_valid = valid_q;

	always_comb begin
		logic [7:0] b3, b4;
		logic       zero, full;
		reply_n  = reply_q;
		mreply_n = mreply_q;
		hbtn_n   = hbtn_q;
		hstk_n   = hstk_q;
		hmode_n  = hmode_q;
		if (ev.cap) begin
			if (ev.cap_idx == BIDX_W'(1))
				mreply_n = ev.cap_val;
			for (int k = 0; k < 7; k++)
				if (ev.cap_idx == BIDX_W'(k + 2))
					reply_n[k] = ev.cap_val;
		end
		b3 = reply_n[1];
		b4 = reply_n[2];
		if (b3 == 8'h00 && b4 == 8'h00) begin
			b3 = BYTE_FULL;
			b4 = BYTE_FULL;
		end
		zero = 1'b1;
		full = 1'b1;
		for (int k = 0; k < 4; k++) begin
			if (reply_n[k + 3] != 8'h00)  zero = 1'b0;
			if (reply_n[k + 3] != BYTE_FULL) full = 1'b0;
		end
		if (ev.done) begin
			hbtn_n = ~{b4, b3};
			if (zero || full) begin
				hstk_n[0] = STICK_MID_X;
				hstk_n[1] = STICK_MID_Y;
				hstk_n[2] = STICK_MID_X;
				hstk_n[3] = STICK_MID_Y;
			end else begin
				for (int k = 0; k < 4; k++)
					hstk_n[k] = reply_n[k + 3];
			end
			hmode_n = mreply_n;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			reply_q <= reply_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mreply_q  <= 8'h00;
			hbtn_q    <= 16'h0000;
			hstk_q[0] <= STICK_MID_X;
			hstk_q[1] <= STICK_MID_Y;
			hstk_q[2] <= STICK_MID_X;
			hstk_q[3] <= STICK_MID_Y;
			hmode_q   <= 8'h00;
			valid_q   <= 1'b0;
		end else begin
			if (pop) begin
				mreply_q <= mreply_n;
				hbtn_q   <= hbtn_n;
				hstk_q   <= hstk_n;
				hmode_q  <= hmode_n;
				valid_q  <= 1'b1;
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	// result register: load with the tick just taken from the queue
	always_ff @(posedge clk) begin
		if (pop) begin
			select_n   <= ev.sel;
			clock_pin  <= ev.clk;
			data_out   <= ev.dout;
			frame_done <= ev.done;
			buttons    <= hbtn_n;
			right_x    <= hstk_n[0];
			right_y    <= hstk_n[1];
			left_x     <= hstk_n[2];
			left_y     <= hstk_n[3];
			mode_id    <= hmode_n;
			is_analog  <= (hmode_n == MODE_ANALOG_RED);
			init_busy  <= ev.busy;
		end
	end

	a_done_not_init: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && frame_done) |-> !init_busy)
		else $error("poll frame finished while init still running");

	a_done_pins: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && frame_done) |-> (clock_pin && !select_n))
		else $error("frame end reported outside the last clock-high tick");

endmodule
